>>> rtl/core/deque_with_remove_by_value_macros.svh
// ----------------------------------------------------------------------------
// deque macros
// assertion shorthands used by the deque top level
// ----------------------------------------------------------------------------
`ifndef DEQUE_WITH_REMOVE_BY_VALUE_MACROS_SVH
`define DEQUE_WITH_REMOVE_BY_VALUE_MACROS_SVH

// property sampled on clk_i, quiet while rst_ni is low
`define DWR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// next-cycle implication built on the plain form
`define DWR_ASSERT_NEXT(lbl, ante, cons, msg) \
  `DWR_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

>>> rtl/core/dwr_pkg.sv
// ----------------------------------------------------------------------------
// dwr_pkg
// sizes, codes, types and word conversions for the deque
// ----------------------------------------------------------------------------
package dwr_pkg;

  localparam int unsigned CAPACITY   = 64;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned CNT_W      = $clog2(CAPACITY + 1);
  localparam int unsigned LOG_N      = $clog2(CAPACITY);

  typedef logic [DATA_WIDTH-1:0] word_t;
  typedef logic [CAPACITY-1:0]   vec_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  typedef enum logic [2:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_REMOVE     = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    STS_DONE      = 2'd0,
    STS_EMPTY     = 2'd1,
    STS_NOT_FOUND = 2'd2,
    STS_FULL      = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CM_HOLD,
    CM_LOAD,
    CM_FROM_LEFT,
    CM_FROM_RIGHT
  } cell_mode_e;

  // removal choice handed from the picker to the top level
  typedef struct packed {
    logic found;
    vec_t sel;
    vec_t shift;
    vec_t last;
  } pick_t;

  // low bits of the sign-extended request value
  function automatic word_t to_word(logic [31:0] raw);
    logic signed [63:0] ext;
    ext = 64'(signed'(raw));
    return ext[DATA_WIDTH-1:0];
  endfunction

  // sign-extend a stored word back to the 32-bit result
  function automatic logic [31:0] word_to_out(word_t w);
    logic signed [DATA_WIDTH-1:0] s;
    logic signed [63:0]           ext;
    s   = w;
    ext = 64'(s);
    return ext[31:0];
  endfunction

endpackage

>>> rtl/core/dwr_cell.sv
// ----------------------------------------------------------------------------
// dwr_cell
// one deque entry: word register, neighbour shift and match compare
// ----------------------------------------------------------------------------
module dwr_cell (
  input  logic                clk_i,
  input  logic                cmp_en_i,
  input  logic                in_range_i,
  input  dwr_pkg::word_t      cmp_val_i,
  input  dwr_pkg::cell_mode_e mode_i,
  input  dwr_pkg::word_t      load_i,
  input  dwr_pkg::word_t      left_i,
  input  dwr_pkg::word_t      right_i,
  output dwr_pkg::word_t      data_o,
  output logic                match_o
);
  import dwr_pkg::*;

  word_t data_q, data_d;
  logic  match_q, match_d;

  always_comb begin
    unique case (mode_i)
      CM_LOAD:       data_d = load_i;
      CM_FROM_LEFT:  data_d = left_i;
      CM_FROM_RIGHT: data_d = right_i;
      default:       data_d = data_q;
    endcase
    match_d = cmp_en_i ? (in_range_i && (data_q == cmp_val_i)) : match_q;
  end

  always_ff @(posedge clk_i) begin
    data_q  <= data_d;
    match_q <= match_d;
  end

  assign data_o  = data_q;
  assign match_o = match_q;

endmodule

>>> rtl/core/dwr_pick.sv
// ----------------------------------------------------------------------------
// dwr_pick
// chooses the entry a removal takes and the cells that shift to fill the gap
// ----------------------------------------------------------------------------
module dwr_pick (
  input  dwr_pkg::vec_t  match_i,
  input  dwr_pkg::cnt_t  count_i,
  output dwr_pkg::pick_t pick_o
);
  import dwr_pkg::*;

  // set every bit at and above the lowest set bit, log-depth
  function automatic vec_t spread_up(vec_t v);
    vec_t p;
    p = v;
    for (int k = 0; k < LOG_N; k++) begin
      p = p | (p << (1 << k));
    end
    return p;
  endfunction

  vec_t last, first;
  logic back_hit;

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      last[i] = (CNT_W'(i + 1) == count_i);
    end
    back_hit = |(match_i & last);
    // lowest match only
    first    = match_i & ~spread_up(match_i << 1);

    pick_o.last  = last;
    pick_o.found = |match_i;
    if (match_i[0]) begin
      pick_o.sel = vec_t'(1);
    end else if (back_hit) begin
      pick_o.sel = last;
    end else begin
      pick_o.sel = first;
    end
    pick_o.shift = spread_up(pick_o.sel);
  end

endmodule

>>> rtl/core/deque_with_remove_by_value.sv
// ----------------------------------------------------------------------------
// deque_with_remove_by_value
// bounded double-ended queue of signed words with removal by value
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Each request gives
// exactly one result, shown for one cycle with done_o high; the receiver
// cannot hold it off, so it must take it in that cycle. In the accept cycle
// every cell compares its word with the request value at once, and in the
// following cycle (busy high) the row of cells shifts, loads or holds in one
// step. The result appears in the cycle after that, while busy is already
// low, so a new request can be taken in the same cycle as the previous
// result. No new request is taken while the previous one is being applied.
// Status codes: done, empty (pop or remove on an empty queue), not found,
// full (push refused). count_o is the number of entries after the request.
// ----------------------------------------------------------------------------
`include "deque_with_remove_by_value_macros.svh"

module deque_with_remove_by_value (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         action_i,
  input  logic signed [31:0] item_value_i,
  output logic               done_o,
  output logic signed [31:0] out_value_o,
  output logic [1:0]         status_o,
  output logic [6:0]         count_o
);
  import dwr_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_APPLY
  } state_e;

  state_e      state_q, state_d;
  logic [2:0]  action_q, action_d;
  word_t       val_q, val_d;
  cnt_t        count_q, count_d;
  logic        done_q, done_d;
  status_e     status_q, status_d;
  logic [31:0] out_value_q, out_value_d;

  // cell row
  word_t      data   [CAPACITY];
  cell_mode_e mode   [CAPACITY];
  vec_t       match;
  vec_t       in_range;
  logic       accept;
  word_t      cmp_val;
  pick_t      pick;
  word_t      back_data;
  word_t      res_word;
  action_e    act;
  logic       empty, full;

  assign accept  = start && !busy;
  assign cmp_val = to_word(item_value_i);

  // entries below the current count take part in the compare
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      in_range[i] = (CNT_W'(i) < count_q);
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    word_t left_w, right_w;
    if (g == 0) begin : g_head
      assign left_w = val_q;
    end else begin : g_inner_l
      assign left_w = data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_tail
      assign right_w = data[g];
    end else begin : g_inner_r
      assign right_w = data[g+1];
    end

    dwr_cell u_cell (
      .clk_i      (clk_i),
      .cmp_en_i   (accept),
      .in_range_i (in_range[g]),
      .cmp_val_i  (cmp_val),
      .mode_i     (mode[g]),
      .load_i     (val_q),
      .left_i     (left_w),
      .right_i    (right_w),
      .data_o     (data[g]),
      .match_o    (match[g])
    );
  end

  dwr_pick u_pick (
    .match_i (match),
    .count_i (count_q),
    .pick_o  (pick)
  );

  // word at the back of the queue, and-or over the cells
  always_comb begin
    back_data = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      back_data = back_data | (data[i] & {DATA_WIDTH{pick.last[i]}});
    end
  end

  assign act   = action_e'(action_q);
  assign empty = (count_q == '0);
  assign full  = (count_q == CNT_W'(CAPACITY));

  always_comb begin
    state_d  = state_q;
    action_d = action_q;
    val_d    = val_q;
    count_d  = count_q;
    done_d   = 1'b0;
    status_d = status_q;
    res_word = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      mode[i] = CM_HOLD;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d  = ST_APPLY;
          action_d = action_i;
          val_d    = cmp_val;
        end
      end
      ST_APPLY: begin
        state_d  = ST_IDLE;
        done_d   = 1'b1;
        status_d = STS_DONE;
        unique case (act) inside
          ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
            if (full) begin
              status_d = STS_FULL;
            end else begin
              count_d = count_q + CNT_W'(1);
              for (int i = 0; i < CAPACITY; i++) begin
                if (act == ACT_PUSH_FRONT) begin
                  // whole row moves back, head takes the new word
                  mode[i] = CM_FROM_LEFT;
                end else if (CNT_W'(i) == count_q) begin
                  mode[i] = CM_LOAD;
                end
              end
            end
          end
          ACT_POP_FRONT: begin
            if (empty) begin
              status_d = STS_EMPTY;
            end else begin
              res_word = data[0];
              count_d  = count_q - CNT_W'(1);
              for (int i = 0; i < CAPACITY; i++) begin
                mode[i] = CM_FROM_RIGHT;
              end
            end
          end
          ACT_POP_BACK: begin
            if (empty) begin
              status_d = STS_EMPTY;
            end else begin
              res_word = back_data;
              count_d  = count_q - CNT_W'(1);
            end
          end
          ACT_REMOVE: begin
            if (empty) begin
              status_d = STS_EMPTY;
            end else if (!pick.found) begin
              status_d = STS_NOT_FOUND;
            end else begin
              // matching entry equals the request value
              res_word = val_q;
              count_d  = count_q - CNT_W'(1);
              for (int i = 0; i < CAPACITY; i++) begin
                if (pick.shift[i]) begin
                  mode[i] = CM_FROM_RIGHT;
                end
              end
            end
          end
          default: begin
            // unknown action: nothing changes
            status_d = STS_DONE;
          end
        endcase
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    out_value_d = word_to_out(res_word);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      action_q    <= '0;
      val_q       <= '0;
      count_q     <= '0;
      done_q      <= 1'b0;
      status_q    <= STS_DONE;
      out_value_q <= '0;
    end else begin
      state_q     <= state_d;
      action_q    <= action_d;
      val_q       <= val_d;
      count_q     <= count_d;
      done_q      <= done_d;
      status_q    <= status_d;
      out_value_q <= out_value_d;
    end
  end

  assign busy        = (state_q == ST_APPLY);
  assign done_o      = done_q;
  assign out_value_o = signed'(out_value_q);
  assign status_o    = status_q;
  assign count_o     = 7'(count_q);

  // every accepted request is applied in the cycle after, and answered once busy falls
  `DWR_ASSERT_NEXT(a_accept_apply, accept, busy && !done_o, "accepted request not applied")
  `DWR_ASSERT_NEXT(a_apply_done, busy, done_o && !busy, "applied request gave no result")
  `DWR_ASSERT(a_count_bound, count_q <= CNT_W'(CAPACITY), "entry count above capacity")
  `DWR_ASSERT(a_pick_onehot, $onehot0(pick.sel), "removal picks more than one entry")

endmodule
